// ----- src/sepd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and channel tables of the servo easing PWM driver.
// Depends on nothing; every other file imports it.
package sepd_pkg;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam logic [3:0] TAIL_CH = 4'd4;
    localparam logic [7:0] MAX_DEG = 8'd180;

    // Reciprocal of 9 scaled by 100*1024, exact as a floor for angles up to 180.
    localparam logic [13:0] CMP_RECIP = 14'd11378;
    localparam logic [11:0] CMP_BASE = 12'd500;

    localparam logic [15:0] SNAP_GAP = 16'd128;
    localparam logic [15:0] MOVE_GAP = 16'd256;
    localparam logic [15:0] STEP_MIN = 16'd256;
    localparam logic [15:0] STEP_HALF = 16'd128;
    localparam logic [15:0] STEP_MAX = 16'd768;

    typedef struct packed {
        logic       op;
        logic [2:0] channel;
        logic [7:0] angle;
    } cmd_t;

    function automatic logic signed [5:0] chan_offset(input logic [3:0] c);
        logic signed [5:0] r;
        case (c)
            4'd1, 4'd3: r = -6'sd10;
            4'd2:       r = 6'sd10;
            default:    r = 6'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] reset_target(input logic [3:0] c);
        logic [7:0] r;
        case (c)
            TAIL_CH: r = 8'd0;
            default: r = 8'd90;
        endcase
        return r;
    endfunction

endpackage

// ----- src/sepd_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input words, saturates target angles and drops sets to
// absent channels, then holds one command for the queue. Uses sepd_pkg.
module sepd_front import sepd_pkg::*; #(
    parameter int NUM_SERVOS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  logic        cmd_ready
);

    localparam logic [4:0] NS = 5'(NUM_SERVOS);

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic valid_reg;
    logic valid_next;
    logic [7:0] angle_in;
    logic keep;

    assign s_tready = !valid_reg || cmd_ready;
    assign angle_in = s_tdata[10:3];
    assign keep = (s_tuser == OP_TICK) || ({2'b00, s_tdata[2:0]} < NS);

    always_comb
    begin
        cmd_next = cmd_reg;
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid && keep;
            cmd_next.op = s_tuser;
            cmd_next.channel = s_tdata[2:0];
            cmd_next.angle = (angle_in > MAX_DEG) ? MAX_DEG : angle_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

// ----- src/sepd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the easing engine.
// Uses cmd_t and CMD_FIFO_DEPTH from sepd_pkg.
module sepd_cmd_fifo import sepd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_cmd,
    input  logic wr_valid,
    output logic wr_ready,
    output cmd_t rd_cmd,
    output logic rd_valid,
    input  logic rd_ready
);

    localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(CMD_FIFO_DEPTH - 1);
    localparam logic [PW:0] FULL_CNT = (PW + 1)'(CMD_FIFO_DEPTH);

    cmd_t mem_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0] count_reg;
    logic push;
    logic pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- src/sepd_back.sv -----
`timescale 1ns / 1ps
// Easing engine: stores targets, eases every channel one per cycle on a tick,
// then emits one result word per channel through an output register. Uses sepd_pkg.
module sepd_back import sepd_pkg::*; #(
    parameter int NUM_SERVOS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [7:0]  gain,
    input  logic        tail_enable,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam int IW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SERVOS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EASE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic any_reg, any_next;
    logic [NUM_SERVOS-1:0] moving_reg, moving_next;
    logic [7:0] target_reg [NUM_SERVOS];
    logic [7:0] target_next [NUM_SERVOS];
    logic [15:0] current_reg [NUM_SERVOS];
    logic [15:0] current_next [NUM_SERVOS];
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;

    logic [15:0] t16;
    logic [15:0] n16;
    logic [15:0] gap;
    logic [23:0] prod;
    logic [15:0] step_raw;
    logic [15:0] step;
    logic [15:0] n_new;
    logic [15:0] gap_new;
    logic mv;

    logic [3:0] idx4;
    logic [7:0] deg;
    logic signed [9:0] sa;
    logic [7:0] a_clamp;
    logic [7:0] a_map;
    logic [21:0] cmp_prod;
    logic [11:0] cmp;
    logic wr_flag;
    logic out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign idx4 = 4'(idx_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        t16 = {target_reg[idx_reg], 8'h00};
        n16 = current_reg[idx_reg];
        gap = (t16 >= n16) ? (t16 - n16) : (n16 - t16);
        prod = gap * {8'h00, gain};
        step_raw = prod[23:8];
        if (step_raw < STEP_MIN)
        begin
            step = STEP_HALF;
        end
        else if (step_raw > STEP_MAX)
        begin
            step = STEP_MAX;
        end
        else
        begin
            step = step_raw;
        end
        if (gap < SNAP_GAP)
        begin
            n_new = t16;
            gap_new = '0;
        end
        else if (prod == '0)
        begin
            n_new = n16;
            gap_new = gap;
        end
        else
        begin
            n_new = (t16 < n16) ? (n16 - step) : (n16 + step);
            gap_new = gap - step;
        end
        mv = (gap_new > MOVE_GAP);
    end

    always_comb
    begin
        deg = current_reg[idx_reg][15:8];
        sa = $signed({2'b00, deg}) + 10'(chan_offset(idx4));
        if (sa > $signed({2'b00, MAX_DEG}))
        begin
            a_clamp = MAX_DEG;
        end
        else if (sa < 10'sd0)
        begin
            a_clamp = '0;
        end
        else
        begin
            a_clamp = sa[7:0];
        end
        a_map = (idx4 == 4'd0 || idx4 == 4'd2) ? (MAX_DEG - a_clamp) : a_clamp;
        cmp_prod = a_map * CMP_RECIP;
        cmp = CMP_BASE + cmp_prod[21:10];
        wr_flag = !((NUM_SERVOS > 4) && (idx4 == TAIL_CH) && !tail_enable);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        any_next = any_reg;
        moving_next = moving_reg;
        target_next = target_reg;
        current_next = current_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_TICK)
                    begin
                        state_next = ST_EASE;
                        idx_next = '0;
                        any_next = 1'b0;
                    end
                    else
                    begin
                        target_next[IW'(cmd.channel)] = cmd.angle;
                    end
                end
            end
            ST_EASE:
            begin
                current_next[idx_reg] = n_new;
                moving_next[idx_reg] = mv;
                any_next = any_reg | mv;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {6'b000000, any_reg, moving_reg[idx_reg], deg,
                                     wr_flag, cmp, 3'(idx_reg)};
                    out_last_next = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            any_reg <= 1'b0;
            moving_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_SERVOS; c++)
            begin
                target_reg[c] <= reset_target(4'(c));
                current_reg[c] <= {reset_target(4'(c)), 8'h00};
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            any_reg <= any_next;
            moving_reg <= moving_next;
            out_valid_reg <= out_valid_next;
            target_reg <= target_next;
            current_reg <= current_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

endmodule

// ----- src/servo_easing_pwm_driver_top.sv -----
`timescale 1ns / 1ps
// Servo easing PWM driver top level: front end, command queue, easing engine.
// A set word only updates a target and leaves the engine idle; a tick word occupies
// it while it is accepted, for one easing pass, then for one result word per channel
// (longer under output stall). The first result is set into the output register once
// the easing pass is done. Reset restores targets and
// angles to 90 degrees (channel 4 to 0), gain to 77 and tail enable to 1.
module servo_easing_pwm_driver_top import sepd_pkg::*; #(
    parameter int NUM_SERVOS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // channel[2:0], angle[10:3], zero[15:11]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // servo_index[2:0], compare_value[14:3], written[15], angle_now[23:16],
    // moving[24], any_moving[25], zero[31:26]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_TAIL = 1'b1;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;
    logic [7:0] gain_reg;
    logic tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 8'd77;
            tail_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN: gain_reg <= cfg_data;
                CFG_TAIL: tail_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sepd_front #(
        .NUM_SERVOS(NUM_SERVOS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .cmd(front_cmd),
        .cmd_valid(front_valid),
        .cmd_ready(front_ready)
    );

    sepd_cmd_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_cmd(front_cmd),
        .wr_valid(front_valid),
        .wr_ready(front_ready),
        .rd_cmd(queue_cmd),
        .rd_valid(queue_valid),
        .rd_ready(queue_ready)
    );

    sepd_back #(
        .NUM_SERVOS(NUM_SERVOS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(queue_cmd),
        .cmd_valid(queue_valid),
        .cmd_ready(queue_ready),
        .gain(gain_reg),
        .tail_enable(tail_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

endmodule
